// ===== src/rmwf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmwf_pkg: shared types and constants for the recursive mutex unit
// Sizes of the thread space, nesting counter and waiter FIFO, and status codes.
// ----------------------------------------------------------------------------
package rmwf_pkg;

	localparam int THREAD_COUNT = 16;
	localparam int COUNT_BITS   = 8;

	// Fixed payload widths of the request and response transfers.
	localparam int TID_BITS    = 4;
	localparam int STATUS_BITS = 3;
	localparam int REPEAT_BITS = 8;

	localparam int QIDX_BITS = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
	localparam int FILL_BITS = $clog2(THREAD_COUNT + 1);

	typedef enum logic [0:0] {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_GRANTED         = 3'd0,
		ST_BLOCKED         = 3'd1,
		ST_LOWERED         = 3'd2,
		ST_FREED           = 3'd3,
		ST_NOT_HOLDER      = 3'd4,
		ST_ALREADY_WAITING = 3'd5,
		ST_QUEUE_FULL      = 3'd6,
		ST_OVERFLOW        = 3'd7
	} status_t;

endpackage

// ===== src/rmwf_req_if.sv =====
// ----------------------------------------------------------------------------
// rmwf_req_if: request channel of the recursive mutex unit
// One transfer carries an acquire or release request from a numbered thread.
// ----------------------------------------------------------------------------
interface rmwf_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [rmwf_pkg::TID_BITS-1:0] thread_id;

	modport source (output valid, output operation, output thread_id, input ready);
	modport sink   (input valid, input operation, input thread_id, output ready);
endinterface

// ===== src/rmwf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rmwf_rsp_if: response channel of the recursive mutex unit
// One transfer carries the status, wake-up and nesting count of one request.
// ----------------------------------------------------------------------------
interface rmwf_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [rmwf_pkg::STATUS_BITS-1:0] status;
	logic                             wake_valid;
	logic [rmwf_pkg::TID_BITS-1:0]    wake_thread;
	logic [rmwf_pkg::REPEAT_BITS-1:0] repeat_count;

	modport source (
		output valid, output status, output wake_valid, output wake_thread,
		output repeat_count, input ready
	);
	modport sink (
		input valid, input status, input wake_valid, input wake_thread,
		input repeat_count, output ready
	);
endinterface

// ===== src/recursive_mutex_with_waiter_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// recursive_mutex_with_waiter_fifo_unit: recursive lock with a FIFO of waiters
// Flow: a request waits in the request register until its response can be
// registered; the response then holds until it is transferred.
// Throughput: one request per cycle while the response is not stalled; the
// lock state is read and updated between the request and response registers.
// Reset: asynchronous, active low; lock free, count zero, waiter FIFO empty.
// ----------------------------------------------------------------------------
module recursive_mutex_with_waiter_fifo_unit (
	input  logic       clk,
	input  logic       arst_n,
	rmwf_req_if.sink   req,
	rmwf_rsp_if.source rsp
);

	// Request register
	logic                          valid_s1;
	logic                          op_s1;
	logic [rmwf_pkg::TID_BITS-1:0] tid_s1;

	// Lock state
	logic                                lock_taken_q;
	logic [rmwf_pkg::TID_BITS-1:0]       holder_q;
	logic [rmwf_pkg::COUNT_BITS-1:0]     count_q;
	logic [rmwf_pkg::TID_BITS-1:0]       queue_q [rmwf_pkg::THREAD_COUNT];
	logic [rmwf_pkg::QIDX_BITS-1:0]      head_q;
	logic [rmwf_pkg::FILL_BITS-1:0]      fill_q;
	logic [rmwf_pkg::THREAD_COUNT-1:0]   waiting_q;

	// Response register
	logic                             rsp_valid_q;
	rmwf_pkg::status_t                status_q;
	logic                             wake_valid_q;
	logic [rmwf_pkg::TID_BITS-1:0]    wake_thread_q;
	logic [rmwf_pkg::REPEAT_BITS-1:0] repeat_q;

	logic advance;

	// Next values worked out from the request register and the state
	logic                             known;
	logic [rmwf_pkg::QIDX_BITS-1:0]   tid_idx;
	logic                             is_holder;
	logic                             is_waiting;
	logic                             queue_full;
	logic [rmwf_pkg::QIDX_BITS:0]     tail_sum;
	logic [rmwf_pkg::QIDX_BITS-1:0]   tail_idx;
	logic [rmwf_pkg::QIDX_BITS-1:0]   head_inc;
	logic [rmwf_pkg::TID_BITS-1:0]    head_thread;
	logic [rmwf_pkg::QIDX_BITS-1:0]   wake_idx;
	logic                             wake_known;

	rmwf_pkg::status_t                status_d;
	logic                             wake_valid_d;
	logic [rmwf_pkg::TID_BITS-1:0]    wake_thread_d;
	logic                             lock_taken_d;
	logic [rmwf_pkg::TID_BITS-1:0]    holder_d;
	logic [rmwf_pkg::COUNT_BITS-1:0]  count_d;
	logic                             push;
	logic                             pop;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1  <= req.operation;
			tid_s1 <= req.thread_id;
		end
	end

	assign known = ({1'b0, 32'(tid_s1)} < {1'b0, 32'(rmwf_pkg::THREAD_COUNT)});
	assign tid_idx    = rmwf_pkg::QIDX_BITS'(tid_s1);
	assign is_holder  = lock_taken_q && (holder_q == tid_s1);
	assign is_waiting = known && waiting_q[tid_idx];
	assign queue_full = (32'(fill_q) >= 32'(rmwf_pkg::THREAD_COUNT));

	// Tail position wraps round the FIFO; the sum stays below twice its depth.
	assign tail_sum = {1'b0, head_q} + (rmwf_pkg::QIDX_BITS+1)'(fill_q);
	assign tail_idx = (32'(tail_sum) >= 32'(rmwf_pkg::THREAD_COUNT))
		? rmwf_pkg::QIDX_BITS'(32'(tail_sum) - 32'(rmwf_pkg::THREAD_COUNT))
		: rmwf_pkg::QIDX_BITS'(tail_sum);
	assign head_inc = (32'(head_q) == 32'(rmwf_pkg::THREAD_COUNT) - 32'd1)
		? '0 : head_q + 1'b1;
	assign head_thread = queue_q[head_q];
	assign wake_idx    = rmwf_pkg::QIDX_BITS'(head_thread);
	assign wake_known  = ({1'b0, 32'(head_thread)} < {1'b0, 32'(rmwf_pkg::THREAD_COUNT)});

	always_comb begin
		status_d      = rmwf_pkg::ST_NOT_HOLDER;
		wake_valid_d  = 1'b0;
		wake_thread_d = '0;
		lock_taken_d  = lock_taken_q;
		holder_d      = holder_q;
		count_d       = count_q;
		push          = 1'b0;
		pop           = 1'b0;
		if (op_s1 == rmwf_pkg::OP_ACQUIRE) begin
			if (is_holder) begin
				if (&count_q) begin
					status_d = rmwf_pkg::ST_OVERFLOW;
				end else begin
					status_d = rmwf_pkg::ST_GRANTED;
					count_d  = count_q + 1'b1;
				end
			end else if (is_waiting) begin
				status_d = rmwf_pkg::ST_ALREADY_WAITING;
			end else if (!lock_taken_q) begin
				status_d     = rmwf_pkg::ST_GRANTED;
				lock_taken_d = 1'b1;
				holder_d     = tid_s1;
				count_d      = rmwf_pkg::COUNT_BITS'(1);
			end else if (!known || queue_full) begin
				status_d = rmwf_pkg::ST_QUEUE_FULL;
			end else begin
				status_d = rmwf_pkg::ST_BLOCKED;
				push     = 1'b1;
			end
		end else begin
			if (!is_holder) begin
				status_d = rmwf_pkg::ST_NOT_HOLDER;
			end else if (count_q > rmwf_pkg::COUNT_BITS'(1)) begin
				status_d = rmwf_pkg::ST_LOWERED;
				count_d  = count_q - 1'b1;
			end else begin
				status_d     = rmwf_pkg::ST_FREED;
				lock_taken_d = 1'b0;
				holder_d     = '0;
				count_d      = '0;
				if (fill_q != '0) begin
					pop           = 1'b1;
					wake_valid_d  = 1'b1;
					wake_thread_d = head_thread;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_taken_q <= 1'b0;
			holder_q     <= '0;
			count_q      <= '0;
			head_q       <= '0;
			fill_q       <= '0;
			waiting_q    <= '0;
		end else if (advance) begin
			lock_taken_q <= lock_taken_d;
			holder_q     <= holder_d;
			count_q      <= count_d;
			if (push) begin
				fill_q             <= fill_q + 1'b1;
				waiting_q[tid_idx] <= 1'b1;
			end else if (pop) begin
				fill_q <= fill_q - 1'b1;
				head_q <= head_inc;
				if (wake_known) begin
					waiting_q[wake_idx] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			queue_q[tail_idx] <= tid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// The count shown is the one left after the request; zero once freed.
	always_ff @(posedge clk) begin
		if (advance) begin
			status_q      <= status_d;
			wake_valid_q  <= wake_valid_d;
			wake_thread_q <= wake_thread_d;
			repeat_q      <= rmwf_pkg::REPEAT_BITS'(lock_taken_d ? count_d : '0);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.wake_valid   = wake_valid_q;
	assign rsp.wake_thread  = wake_thread_q;
	assign rsp.repeat_count = repeat_q;

endmodule

// ===== src/rmwf_checker.sv =====
// ----------------------------------------------------------------------------
// rmwf_checker: port-level checks for the recursive mutex unit
// Watches the response channel for consistency between status and fields, and for a held response while stalled.
// ----------------------------------------------------------------------------
module rmwf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [rmwf_pkg::STATUS_BITS-1:0] status,
	input logic                             wake_valid,
	input logic [rmwf_pkg::TID_BITS-1:0]    wake_thread,
	input logic [rmwf_pkg::REPEAT_BITS-1:0] repeat_count
);

	// A wake-up can only come with the lock being freed.
	a_wake_on_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && wake_valid |-> status == rmwf_pkg::ST_FREED)
		else $error("wake-up reported without the lock being freed");

	a_wake_thread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !wake_valid |-> wake_thread == '0)
		else $error("wake thread non-zero without a wake-up");

	// A freed lock has no holder; a grant leaves at least one level of nesting.
	a_count_by_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status != rmwf_pkg::ST_FREED || repeat_count == '0)
			&& (status != rmwf_pkg::ST_GRANTED || repeat_count != '0))
		else $error("repeat count inconsistent with status");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
			&& $stable(wake_valid) && $stable(wake_thread) && $stable(repeat_count))
		else $error("response changed while stalled");

endmodule

bind recursive_mutex_with_waiter_fifo_unit rmwf_checker u_rmwf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.wake_valid   (rsp.wake_valid),
	.wake_thread  (rsp.wake_thread),
	.repeat_count (rsp.repeat_count)
);
